/* hw/rtl/sams_pkg.sv */
// Package with constants, types and codes for the shared-array multi-stack.
package sams_pkg;

  localparam int unsigned Depth     = 64;
  localparam int unsigned Stacks    = 4;
  localparam int unsigned DataWidth = 32;
  localparam int unsigned AddrW     = $clog2(Depth);
  localparam int unsigned CntW      = $clog2(Depth + 1);
  localparam int unsigned SidxW     = $clog2(Stacks);

  typedef enum logic [1:0] {
    FUNC_PUSH  = 2'd0,
    FUNC_POP   = 2'd1,
    FUNC_PEEK  = 2'd2,
    FUNC_CLEAR = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_BAD   = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]  func;
    logic [2:0]  stack_index;
    logic signed [31:0] push_value;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic signed [31:0] top_value;
    logic [5:0]  top_position;
    logic [6:0]  stack_count;
    logic [6:0]  total_count;
  } out_word_t;

endpackage

/* hw/rtl/sams_ram.sv */
// Generic single-port RAM with a registered read.
module sams_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end
endmodule

/* hw/rtl/shared_array_multi_stack.sv */
// Top level of the shared-array multi-stack.
// Several stacks share one element store; each stack owns the region from its
// base up to the next stack's base (the last one up to the end of the store).
// The input channel (in_valid_i/in_ready_o, in_word_i) carries one operation
// word: push, pop, peek or clear. The output channel (out_valid_o/out_ready_i,
// out_word_o) returns exactly one result word per operation.
// The block works on one word at a time; in_ready_o is high only when it is
// idle and its output register is free.
// Pop and peek pass through S_DEC, S_RWAIT and S_RDONE before out_valid_o
// rises (the store is addressed, then read through its registered port). Clear,
// bad-index and empty pop or peek words are answered from S_DEC.
// A push into a stack with room goes through S_DEC and S_WRITE. A push into a
// full stack moves whole neighbor stacks one place, each element with a read
// then a write on the single store port.
// Reset empties every stack and restores the even layout at once; the store
// contents are left as they are and are never read before being written.
// When the receiver stalls, the result waits in the output register and no
// new word is taken until it has been delivered.
module shared_array_multi_stack
  import sams_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_word_o
);

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_DEC   = 11'b00000000010,
    S_RWAIT = 11'b00000000100,
    S_RDONE = 11'b00000001000,
    S_RSEL  = 11'b00000010000,
    S_RMOV  = 11'b00000100000,
    S_LSEL  = 11'b00001000000,
    S_LMOV  = 11'b00010000000,
    S_CHK   = 11'b00100000000,
    S_WRITE = 11'b01000000000,
    S_MWR   = 11'b10000000000
  } state_e;

  state_e state_q, state_d;
  logic [AddrW:0]     base_q [Stacks];
  logic [AddrW:0]     base_d [Stacks];
  logic [CntW-1:0]    cnt_q  [Stacks];
  logic [CntW-1:0]    cnt_d  [Stacks];
  in_word_t           op_q, op_d;
  logic [SidxW-1:0]   k_q, k_d;
  logic [SidxW-1:0]   j_q, j_d;    // stack being moved
  logic [CntW-1:0]    i_q, i_d;    // element step inside a move
  logic               left_q, left_d;
  logic               out_valid_q, out_valid_d;
  out_word_t          out_q, out_d;

  logic               we;
  logic [AddrW-1:0]   addr;
  logic [DataWidth-1:0] wdata, rdata;

  sams_ram #(.Width(DataWidth), .Depth(Depth)) u_ram (
    .clk_i, .we_i(we), .addr_i(addr), .wdata_i(wdata), .rdata_o(rdata)
  );

  function automatic logic [AddrW:0] limit_of(input logic [SidxW-1:0] s,
                                              input logic [AddrW:0] b [Stacks]);
    logic [AddrW:0] r;
    r = (AddrW + 1)'(Depth);
    if (32'(s) + 1 < Stacks) r = b[s + SidxW'(1)];
    return r;
  endfunction

  logic [CntW:0] total;
  always_comb begin
    total = '0;
    for (int s = 0; s < Stacks; s++) total = total + (CntW + 1)'(cnt_q[s]);
  end

  logic [AddrW+1:0] k_end;
  logic             k_full, j_room_r, j_room_l;
  logic [AddrW+1:0] j_end, jm_end;
  always_comb begin
    k_end    = (AddrW + 2)'(base_q[k_q]) + (AddrW + 2)'(cnt_q[k_q]);
    k_full   = k_end >= (AddrW + 2)'(limit_of(k_q, base_q));
    j_end    = (AddrW + 2)'(base_q[j_q]) + (AddrW + 2)'(cnt_q[j_q]);
    j_room_r = j_end < (AddrW + 2)'(limit_of(j_q, base_q));
    jm_end   = (AddrW + 2)'(base_q[j_q - SidxW'(1)]) +
               (AddrW + 2)'(cnt_q[j_q - SidxW'(1)]);
    j_room_l = jm_end < (AddrW + 2)'(base_q[j_q]);
  end

  logic bad_idx;
  assign bad_idx = 32'(op_q.stack_index) >= Stacks;

  always_comb begin
    logic [AddrW+1:0] src;
    state_d     = state_q;
    base_d      = base_q;
    cnt_d       = cnt_q;
    op_d        = op_q;
    k_d         = k_q;
    j_d         = j_q;
    i_d         = i_q;
    left_d      = left_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    we          = 1'b0;
    addr        = '0;
    wdata       = op_q.push_value[DataWidth-1:0];
    src         = '0;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          op_d    = in_word_i;
          k_d     = in_word_i.stack_index[SidxW-1:0];
          state_d = S_DEC;
        end
      end
      S_DEC: begin
        out_d = '0;
        if (op_q.func == FUNC_CLEAR) begin
          for (int s = 0; s < Stacks; s++) begin
            base_d[s] = (AddrW + 1)'((s * Depth) / Stacks);
            cnt_d[s]  = '0;
          end
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end else if (bad_idx) begin
          out_d.status      = ST_BAD;
          out_d.total_count = 7'(total);
          out_valid_d       = 1'b1;
          state_d           = S_IDLE;
        end else if (op_q.func == FUNC_PUSH) begin
          if (k_full) begin
            j_d     = SidxW'(Stacks - 1);
            state_d = S_RSEL;
          end else begin
            state_d = S_WRITE;
          end
        end else if (cnt_q[k_q] == '0) begin
          out_d.status      = ST_EMPTY;
          out_d.total_count = 7'(total);
          out_valid_d       = 1'b1;
          state_d           = S_IDLE;
        end else begin
          addr    = AddrW'(k_end - 1);
          state_d = S_RWAIT;
        end
      end
      S_RWAIT: begin
        addr    = AddrW'(k_end - 1);
        state_d = S_RDONE;
      end
      S_RDONE: begin
        out_d.status    = ST_OK;
        out_d.top_value = 32'($signed(rdata));
        if (op_q.func == FUNC_POP) begin
          cnt_d[k_q]          = cnt_q[k_q] - CntW'(1);
          out_d.stack_count   = 7'(cnt_q[k_q] - CntW'(1));
          out_d.total_count   = 7'(total - 1);
        end else begin
          out_d.top_position  = 6'(k_end - 1);
          out_d.stack_count   = 7'(cnt_q[k_q]);
          out_d.total_count   = 7'(total);
        end
        out_valid_d = 1'b1;
        state_d     = S_IDLE;
      end
      // Right pass: stacks from the last down to k+1.
      S_RSEL: begin
        left_d = 1'b0;
        if (j_q <= k_q) begin
          state_d = S_CHK;
        end else if (j_room_r) begin
          i_d     = cnt_q[j_q];
          state_d = (cnt_q[j_q] == '0) ? S_MWR : S_RMOV;
        end else begin
          j_d = j_q - SidxW'(1);
        end
      end
      S_RMOV: begin
        // Read element i-1 of stack j (top first); write it in S_MWR.
        src     = (AddrW + 2)'(base_q[j_q]) + (AddrW + 2)'(i_q) - 1;
        addr    = AddrW'(src);
        state_d = S_MWR;
      end
      // Left pass: stacks 1..k.
      S_LSEL: begin
        left_d = 1'b1;
        if (j_q > k_q || j_q == '0) begin
          state_d = S_CHK;
        end else if (j_room_l) begin
          i_d     = '0;
          state_d = (cnt_q[j_q] == '0) ? S_MWR : S_LMOV;
        end else begin
          j_d = j_q + SidxW'(1);
        end
      end
      S_LMOV: begin
        src     = (AddrW + 2)'(base_q[j_q]) + (AddrW + 2)'(i_q);
        addr    = AddrW'(src);
        state_d = S_MWR;
      end
      S_MWR: begin
        wdata = rdata;
        if (!left_q) begin
          if (i_q == '0) begin
            base_d[j_q] = base_q[j_q] + (AddrW + 1)'(1);
            j_d         = j_q - SidxW'(1);
            state_d     = S_RSEL;
          end else begin
            src     = (AddrW + 2)'(base_q[j_q]) + (AddrW + 2)'(i_q);
            addr    = AddrW'(src);
            we      = src < (AddrW + 2)'(Depth);
            i_d     = i_q - CntW'(1);
            state_d = (i_q == CntW'(1)) ? S_MWR : S_RMOV;
          end
        end else begin
          if (i_q == cnt_q[j_q]) begin
            base_d[j_q] = base_q[j_q] - (AddrW + 1)'(1);
            j_d         = j_q + SidxW'(1);
            state_d     = S_LSEL;
          end else begin
            src     = (AddrW + 2)'(base_q[j_q]) + (AddrW + 2)'(i_q) - 1;
            addr    = AddrW'(src);
            we      = 1'b1;
            i_d     = i_q + CntW'(1);
            state_d = (i_q + CntW'(1) == cnt_q[j_q]) ? S_MWR : S_LMOV;
          end
        end
      end
      S_CHK: begin
        if (!k_full) begin
          state_d = S_WRITE;
        end else if (!left_q) begin
          j_d     = SidxW'(1);
          state_d = S_LSEL;
        end else begin
          out_d.status      = ST_FULL;
          out_d.stack_count = 7'(cnt_q[k_q]);
          out_d.total_count = 7'(total);
          out_valid_d       = 1'b1;
          state_d           = S_IDLE;
        end
      end
      S_WRITE: begin
        addr              = AddrW'(k_end);
        we                = 1'b1;
        cnt_d[k_q]        = cnt_q[k_q] + CntW'(1);
        out_d             = '0;
        out_d.status      = ST_OK;
        out_d.stack_count = 7'(cnt_q[k_q] + CntW'(1));
        out_d.total_count = 7'(total + 1);
        out_valid_d       = 1'b1;
        state_d           = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign in_ready_o  = (state_q == S_IDLE) && !out_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      left_q      <= 1'b0;
      for (int s = 0; s < Stacks; s++) begin
        base_q[s] <= (AddrW + 1)'((s * Depth) / Stacks);
        cnt_q[s]  <= '0;
      end
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      left_q      <= left_d;
      base_q      <= base_d;
      cnt_q       <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q  <= op_d;
    k_q   <= k_d;
    j_q   <= j_d;
    i_q   <= i_d;
    out_q <= out_d;
  end

  // The store never holds more elements than it has entries.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    total <= (CntW + 1)'(Depth)) else $error("total count exceeds store depth");

  // Stack 0 never moves.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    base_q[0] == '0) else $error("stack 0 base moved");

  // No new word is taken while a result waits.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !in_ready_o) else $error("accepting while result pending");

  // A result appears only when leaving a working state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> state_q == S_IDLE) else $error("result without finish");

endmodule

/* tb/testbench.sv */
// Testbench for the shared-array multi-stack: predicted results, random traffic.
`timescale 1ns / 100ps

module testbench
  import sams_pkg::*;
();

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  in_word_t  in_word_i;
  logic      out_valid_o;
  logic      out_ready_i;
  out_word_t out_word_o;

  shared_array_multi_stack u_top (.*);

  // Clock with a 20 ns period.
  initial clk_i = 1'b0;
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Predictor state: element store, per-stack base and element count.
  logic [DataWidth-1:0] mdl_store [Depth];
  int unsigned          mdl_base  [Stacks];
  int unsigned          mdl_cnt   [Stacks];

  in_word_t  op_queue   [$];
  out_word_t want_queue [$];
  int        error_count;
  int        cycle_count;
  bit        stim_done;
  bit        calm_phase;
  bit        hold_off_req;
  int        send_gap;
  int        recv_gap;
  int        hold_cycles;

  function automatic int unsigned limit_of(int unsigned k);
    return (k + 1 < Stacks) ? mdl_base[k + 1] : Depth;
  endfunction

  function automatic bit stack_full(int unsigned k);
    return mdl_base[k] + mdl_cnt[k] >= limit_of(k);
  endfunction

  function automatic void move_up(int unsigned k);
    if (mdl_base[k] + mdl_cnt[k] < limit_of(k)) begin
      for (int i = int'(mdl_cnt[k]); i > 0; i--)
        mdl_store[mdl_base[k] + i] = mdl_store[mdl_base[k] + i - 1];
      mdl_base[k]++;
    end
  endfunction

  function automatic void move_down(int unsigned k);
    if (mdl_base[k - 1] + mdl_cnt[k - 1] < mdl_base[k]) begin
      for (int unsigned i = 0; i < mdl_cnt[k]; i++)
        mdl_store[mdl_base[k] + i - 1] = mdl_store[mdl_base[k] + i];
      mdl_base[k]--;
    end
  endfunction

  function automatic void even_layout();
    for (int unsigned i = 0; i < Stacks; i++) begin
      mdl_base[i] = i * Depth / Stacks;
      mdl_cnt[i]  = 0;
    end
  endfunction

  function automatic int unsigned stored_total();
    int unsigned t;
    t = 0;
    for (int unsigned i = 0; i < Stacks; i++) t += mdl_cnt[i];
    return t;
  endfunction

  // Works out the result word of one operation and updates the predictor.
  function automatic out_word_t stack_op(in_word_t w);
    out_word_t   r;
    int unsigned k;
    int unsigned pos;
    r = '0;
    k = 32'(w.stack_index);
    if (func_e'(w.func) == FUNC_CLEAR) begin
      even_layout();
      return r;
    end
    if (k >= Stacks) begin
      r.status = ST_BAD;
    end else if (func_e'(w.func) == FUNC_PUSH) begin
      if (stack_full(k)) begin
        for (int unsigned j = Stacks - 1; j > k; j--) move_up(j);
        if (stack_full(k))
          for (int unsigned j = 1; j <= k; j++) move_down(j);
      end
      if (stack_full(k)) begin
        r.status = ST_FULL;
      end else begin
        mdl_store[mdl_base[k] + mdl_cnt[k]] = w.push_value;
        mdl_cnt[k]++;
      end
      r.stack_count = 7'(mdl_cnt[k]);
    end else begin
      if (mdl_cnt[k] == 0) begin
        r.status = ST_EMPTY;
      end else begin
        pos = mdl_base[k] + mdl_cnt[k] - 1;
        r.top_value = mdl_store[pos];
        if (func_e'(w.func) == FUNC_POP) mdl_cnt[k]--;
        else r.top_position = 6'(pos);
      end
      r.stack_count = 7'(mdl_cnt[k]);
    end
    r.total_count = 7'(stored_total());
    return r;
  endfunction

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %0h want %0h at cycle %0d", what, got, want, cycle_count);
    error_count++;
  endtask

  function automatic in_word_t make_op(func_e f, int k, logic [31:0] v);
    in_word_t w;
    w.func        = f;
    w.stack_index = 3'(k);
    w.push_value  = v;
    return w;
  endfunction

  // Driver: offers the pending words, with random gaps between them.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_word_i  <= '0;
      send_gap   <= 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        want_queue.push_back(stack_op(in_word_i));
      end
      if (!in_valid_i || in_ready_o) begin
        if (send_gap > 0) begin
          send_gap   <= send_gap - 1;
          in_valid_i <= 1'b0;
        end else if (op_queue.size() > 0) begin
          in_word_i  <= op_queue.pop_front();
          in_valid_i <= 1'b1;
          if (!calm_phase && $urandom_range(0, 9) == 0) send_gap <= $urandom_range(1, 18);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: takes results with random stalls and checks each field.
  always @(posedge clk_i or negedge rst_ni) begin
    out_word_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      recv_gap    <= 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (want_queue.size() == 0) begin
          report("unexpected word", 32'(out_word_o.status), 0);
        end else begin
          want = want_queue.pop_front();
          if (out_word_o.status != want.status)
            report("status", 32'(out_word_o.status), 32'(want.status));
          if (out_word_o.top_value != want.top_value)
            report("top_value", out_word_o.top_value, want.top_value);
          if (out_word_o.top_position != want.top_position)
            report("top_position", 32'(out_word_o.top_position), 32'(want.top_position));
          if (out_word_o.stack_count != want.stack_count)
            report("stack_count", 32'(out_word_o.stack_count), 32'(want.stack_count));
          if (out_word_o.total_count != want.total_count)
            report("total_count", 32'(out_word_o.total_count), 32'(want.total_count));
        end
      end
      if (hold_off_req) begin
        out_ready_i <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap    <= recv_gap - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        if (!calm_phase && $urandom_range(0, 9) == 0) recv_gap <= $urandom_range(1, 18);
      end
    end
  end

  // Long receiver hold-off, counted in its own process, so the block backs up.
  initial begin
    hold_off_req = 1'b0;
    hold_cycles  = 0;
    wait (cycle_count == 400);
    hold_off_req = 1'b1;
    while (hold_cycles < 300) begin
      @(posedge clk_i);
      hold_cycles++;
    end
    hold_off_req = 1'b0;
  end

  // Cycle counter and timeout.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 2000000) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 4))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int k;
    int r;
    error_count = 0;
    cycle_count = 0;
    stim_done   = 1'b0;
    calm_phase  = 1'b0;
    even_layout();
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty pops and peeks, bad indexes, extreme values, clear.
    op_queue.push_back(make_op(FUNC_POP, 0, 0));
    op_queue.push_back(make_op(FUNC_PEEK, 3, 0));
    op_queue.push_back(make_op(FUNC_PUSH, 4, 32'h1234));
    op_queue.push_back(make_op(FUNC_POP, 7, 0));
    op_queue.push_back(make_op(FUNC_PEEK, 5, 0));
    op_queue.push_back(make_op(FUNC_PUSH, 0, 32'h8000_0000));
    op_queue.push_back(make_op(FUNC_PUSH, 3, 32'h7fff_ffff));
    op_queue.push_back(make_op(FUNC_PUSH, 1, 32'hffff_ffff));
    op_queue.push_back(make_op(FUNC_PUSH, 2, 32'h0));
    op_queue.push_back(make_op(FUNC_PEEK, 3, 0));
    op_queue.push_back(make_op(FUNC_POP, 0, 0));
    op_queue.push_back(make_op(FUNC_PEEK, 1, 0));
    op_queue.push_back(make_op(FUNC_CLEAR, 6, 32'hffff_ffff));
    op_queue.push_back(make_op(FUNC_PEEK, 1, 0));
    // Fill stack 3 past its share so neighbors shift, then overflow the store.
    for (int i = 0; i < 70; i++) op_queue.push_back(make_op(FUNC_PUSH, 3, $urandom));
    op_queue.push_back(make_op(FUNC_PEEK, 3, 0));
    op_queue.push_back(make_op(FUNC_CLEAR, 0, 0));
    for (int i = 0; i < 40; i++) op_queue.push_back(make_op(FUNC_PUSH, 0, $urandom));
    op_queue.push_back(make_op(FUNC_CLEAR, 0, 0));

    // Random part: push-heavy bursts to reach shifting, pop-heavy to drain.
    for (int i = 0; i < 1330; i++) begin
      if (i % 200 < 120) r = $urandom_range(0, 9);
      else r = $urandom_range(3, 12);
      if ($urandom_range(0, 15) == 0) k = $urandom_range(4, 7);
      else if ((i / 50) % 3 == 0) k = $urandom_range(0, 1);
      else k = $urandom_range(0, 3);
      if ($urandom_range(0, 150) == 0) op_queue.push_back(make_op(FUNC_CLEAR, k, rand_value()));
      else if (r < 6) op_queue.push_back(make_op(FUNC_PUSH, k, rand_value()));
      else if (r < 10) op_queue.push_back(make_op(FUNC_POP, k, rand_value()));
      else op_queue.push_back(make_op(FUNC_PEEK, k, rand_value()));
      if (i == 1100) begin
        wait (op_queue.size() < 5);
        calm_phase = 1'b1;
      end
    end

    wait (op_queue.size() == 0 && !in_valid_i && want_queue.size() == 0);
    repeat (200) @(posedge clk_i);
    if (error_count == 0 && want_queue.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/sams_pkg.sv
hw/rtl/sams_ram.sv
hw/rtl/shared_array_multi_stack.sv
tb/testbench.sv
